FILE: hdl/isfe_pkg.sv
// shared types, constants and the bucket hash of the address set
package isfe_pkg;

   localparam int CAPACITY = 1024;
   localparam int SLOT_W   = $clog2(CAPACITY);
   localparam int CNT_W    = $clog2(CAPACITY + 1);
   localparam int IP_W     = 32;
   localparam int OP_W     = 2;
   localparam int TOTAL_W  = 11;
   localparam int LINK_W   = SLOT_W + 1;
   localparam int QDEPTH   = 2;
   localparam int Q_PTR_W  = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
   localparam int Q_CNT_W  = $clog2(QDEPTH + 1);

   localparam logic [OP_W-1:0] OP_QUERY = 2'd0;
   localparam logic [OP_W-1:0] OP_ADD   = 2'd1;
   localparam logic [OP_W-1:0] OP_DEL   = 2'd2;

   typedef enum logic [1:0] {
      KIND_QUERY,
      KIND_ADD,
      KIND_DEL
   } kind_type;

   typedef struct packed {
      kind_type            kind;
      logic [IP_W-1:0]     ip;
      logic [SLOT_W-1:0]   bucket;
   } item_type;

   typedef struct packed {
      logic     valid;
      item_type item;
   } qhead_type;

   typedef struct packed {
      logic              valid;
      logic [SLOT_W-1:0] slot;
   } link_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_HEAD,
      ST_CMP,
      ST_MISS,
      ST_EV_KEY,
      ST_UNLINK,
      ST_AGE,
      ST_POP_WAIT,
      ST_INS_HEAD,
      ST_INS,
      ST_RESULT
   } state_type;

   // xor fold of the address down to a bucket index
   function automatic logic [SLOT_W-1:0] bucket_hash(input logic [IP_W-1:0] ip);
      logic [SLOT_W-1:0] h;
      h = '0;
      for (int i = 0; i < IP_W; i++) begin
         h[i % SLOT_W] = h[i % SLOT_W] ^ ip[i];
      end
      return h;
   endfunction

endpackage

FILE: hdl/isfe_ram.sv
// generic single write port, single read port ram with registered read
module isfe_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hdl/isfe_front.sv
// front end: takes commands, classifies the op, hashes the address, queues items
module isfe_front (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  logic [isfe_pkg::OP_W-1:0] op,
   input  logic [isfe_pkg::IP_W-1:0] ip,
   input  logic                      pop,
   output logic                      full,
   output isfe_pkg::qhead_type       head
);
   import isfe_pkg::*;

   item_type             entry_ff [QDEPTH];
   logic [Q_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [Q_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [Q_CNT_W-1:0]   cnt_ff, cnt_in;
   item_type             new_item;
   logic                 do_pop;

   // unused op code behaves as a query
   always_comb begin
      new_item.ip     = ip;
      new_item.bucket = bucket_hash(ip);
      unique case (op)
         OP_ADD:  new_item.kind = KIND_ADD;
         OP_DEL:  new_item.kind = KIND_DEL;
         default: new_item.kind = KIND_QUERY;
      endcase
   end

   assign do_pop = pop && (cnt_ff != '0);
   assign full   = (cnt_ff == Q_CNT_W'(QDEPTH));

   always_comb begin
      rd_ptr_in = rd_ptr_ff;
      wr_ptr_in = wr_ptr_ff;
      cnt_in    = cnt_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == Q_PTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == Q_PTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !do_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (do_pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ptr_ff <= '0;
         wr_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         rd_ptr_ff <= rd_ptr_in;
         wr_ptr_ff <= wr_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= new_item;
      end
   end

   assign head.valid = (cnt_ff != '0);
   assign head.item  = entry_ff[rd_ptr_ff];

endmodule

FILE: hdl/isfe_back.sv
// back end: bucket chain walk, age list relink, slot allocation and result
module isfe_back (
   input  logic                         clock,
   input  logic                         reset,
   input  isfe_pkg::qhead_type          head,
   output logic                         pop,
   output logic                         clearing,
   output logic                         rsp_strobe,
   output logic                         rsp_was_present,
   output logic                         rsp_evicted_valid,
   output logic [isfe_pkg::IP_W-1:0]    rsp_evicted_ip,
   output logic [isfe_pkg::TOTAL_W-1:0] rsp_entry_total
);
   import isfe_pkg::*;

   state_type         st_ff, st_in;
   item_type          item_ff, item_in;
   logic [SLOT_W-1:0] bucket_ff, bucket_in;
   logic [SLOT_W-1:0] cur_ff, cur_in;
   logic [SLOT_W-1:0] prev_ff, prev_in;
   logic              prev_v_ff, prev_v_in;
   link_type          nxt_ff, nxt_in;
   logic [SLOT_W-1:0] slot_ff, slot_in;
   logic              evict_ff, evict_in;
   logic              present_ff, present_in;
   logic              ev_ff, ev_in;
   logic [IP_W-1:0]   ev_ip_ff, ev_ip_in;
   logic [SLOT_W-1:0] oldest_ff, oldest_in;
   logic [SLOT_W-1:0] newest_ff, newest_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [CNT_W-1:0]  fill_ff, fill_in;
   logic [CNT_W-1:0]  top_ff, top_in;
   logic [SLOT_W-1:0] clr_ff, clr_in;

   logic              head_we, key_we, next_we, anext_we, aprev_we, free_we;
   logic [SLOT_W-1:0] head_wa, key_wa, next_wa, anext_wa, aprev_wa, free_wa;
   logic [LINK_W-1:0] head_wd, next_wd, head_rd, next_rd;
   logic [IP_W-1:0]   key_wd, key_rd;
   logic [SLOT_W-1:0] anext_wd, aprev_wd, free_wd, anext_rd, aprev_rd, free_rd;
   logic [SLOT_W-1:0] head_ra, key_ra, anext_ra, free_ra;

   link_type          head_link, next_link;
   logic              match, full;
   logic [SLOT_W-1:0] ev_bucket;

   assign head_link = link_type'(head_rd);
   assign next_link = link_type'(next_rd);
   assign full      = (count_ff == CNT_W'(CAPACITY));
   assign match     = evict_ff ? (cur_ff == oldest_ff) : (key_rd == item_ff.ip);
   assign ev_bucket = bucket_hash(key_rd);

   // chain heads per bucket, cleared after reset
   isfe_ram #(.WIDTH(LINK_W), .DEPTH(CAPACITY)) u_head (
      .clock(clock), .wr_en(head_we), .wr_addr(head_wa), .wr_data(head_wd),
      .rd_addr(head_ra), .rd_data(head_rd)
   );
   // key and chain link share the read address
   isfe_ram #(.WIDTH(IP_W), .DEPTH(CAPACITY)) u_key (
      .clock(clock), .wr_en(key_we), .wr_addr(key_wa), .wr_data(key_wd),
      .rd_addr(key_ra), .rd_data(key_rd)
   );
   isfe_ram #(.WIDTH(LINK_W), .DEPTH(CAPACITY)) u_next (
      .clock(clock), .wr_en(next_we), .wr_addr(next_wa), .wr_data(next_wd),
      .rd_addr(key_ra), .rd_data(next_rd)
   );
   // age list, oldest to newest
   isfe_ram #(.WIDTH(SLOT_W), .DEPTH(CAPACITY)) u_anext (
      .clock(clock), .wr_en(anext_we), .wr_addr(anext_wa), .wr_data(anext_wd),
      .rd_addr(anext_ra), .rd_data(anext_rd)
   );
   isfe_ram #(.WIDTH(SLOT_W), .DEPTH(CAPACITY)) u_aprev (
      .clock(clock), .wr_en(aprev_we), .wr_addr(aprev_wa), .wr_data(aprev_wd),
      .rd_addr(anext_ra), .rd_data(aprev_rd)
   );
   // stack of freed slots
   isfe_ram #(.WIDTH(SLOT_W), .DEPTH(CAPACITY)) u_free (
      .clock(clock), .wr_en(free_we), .wr_addr(free_wa), .wr_data(free_wd),
      .rd_addr(free_ra), .rd_data(free_rd)
   );

   // next state
   always_comb begin
      st_in = st_ff;
      unique case (st_ff)
         ST_CLEAR: begin
            if (clr_ff == SLOT_W'(CAPACITY - 1)) begin
               st_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (head.valid) begin
               st_in = ST_HEAD;
            end
         end
         ST_HEAD: st_in = head_link.valid ? ST_CMP : ST_MISS;
         ST_CMP: begin
            priority if (match) begin
               st_in = (evict_ff || item_ff.kind == KIND_DEL) ? ST_UNLINK : ST_RESULT;
            end else if (next_link.valid) begin
               st_in = ST_CMP;
            end else begin
               st_in = ST_MISS;
            end
         end
         ST_MISS: begin
            priority if (item_ff.kind != KIND_ADD || evict_ff) begin
               st_in = ST_RESULT;
            end else if (full) begin
               st_in = ST_EV_KEY;
            end else if (top_ff != '0) begin
               st_in = ST_POP_WAIT;
            end else begin
               st_in = ST_INS_HEAD;
            end
         end
         ST_EV_KEY:   st_in = ST_HEAD;
         ST_UNLINK:   st_in = ST_AGE;
         ST_AGE:      st_in = evict_ff ? ST_INS_HEAD : ST_RESULT;
         ST_POP_WAIT: st_in = ST_INS_HEAD;
         ST_INS_HEAD: st_in = ST_INS;
         ST_INS:      st_in = ST_RESULT;
         ST_RESULT:   st_in = ST_IDLE;
         default:     st_in = ST_CLEAR;
      endcase
   end

   // datapath and memory control
   always_comb begin
      item_in    = item_ff;
      bucket_in  = bucket_ff;
      cur_in     = cur_ff;
      prev_in    = prev_ff;
      prev_v_in  = prev_v_ff;
      nxt_in     = nxt_ff;
      slot_in    = slot_ff;
      evict_in   = evict_ff;
      present_in = present_ff;
      ev_in      = ev_ff;
      ev_ip_in   = ev_ip_ff;
      oldest_in  = oldest_ff;
      newest_in  = newest_ff;
      count_in   = count_ff;
      fill_in    = fill_ff;
      top_in     = top_ff;
      clr_in     = clr_ff;
      pop        = 1'b0;
      head_we = 1'b0; head_wa = '0; head_wd = '0; head_ra = '0;
      key_we  = 1'b0; key_wa  = '0; key_wd  = '0; key_ra  = '0;
      next_we = 1'b0; next_wa = '0; next_wd = '0;
      anext_we = 1'b0; anext_wa = '0; anext_wd = '0; anext_ra = '0;
      aprev_we = 1'b0; aprev_wa = '0; aprev_wd = '0;
      free_we = 1'b0; free_wa = '0; free_wd = '0; free_ra = '0;
      unique case (st_ff)
         ST_CLEAR: begin
            head_we = 1'b1;
            head_wa = clr_ff;
            clr_in  = clr_ff + 1'b1;
         end
         ST_IDLE: begin
            if (head.valid) begin
               pop        = 1'b1;
               item_in    = head.item;
               bucket_in  = head.item.bucket;
               head_ra    = head.item.bucket;
               evict_in   = 1'b0;
               present_in = 1'b0;
               ev_in      = 1'b0;
               ev_ip_in   = '0;
            end
         end
         ST_HEAD: begin
            cur_in    = head_link.slot;
            prev_v_in = 1'b0;
            key_ra    = head_link.slot;
         end
         ST_CMP: begin
            if (match) begin
               nxt_in = next_link;
               if (!evict_ff) begin
                  present_in = 1'b1;
               end
            end else begin
               prev_in   = cur_ff;
               prev_v_in = 1'b1;
               cur_in    = next_link.slot;
               key_ra    = next_link.slot;
            end
         end
         ST_MISS: begin
            if (item_ff.kind == KIND_ADD && !evict_ff) begin
               priority if (full) begin
                  key_ra = oldest_ff;
               end else if (top_ff != '0) begin
                  free_ra = SLOT_W'(top_ff - 1'b1);
                  top_in  = top_ff - 1'b1;
               end else begin
                  slot_in = SLOT_W'(fill_ff);
                  fill_in = fill_ff + 1'b1;
               end
            end
         end
         ST_EV_KEY: begin
            ev_in     = 1'b1;
            ev_ip_in  = key_rd;
            evict_in  = 1'b1;
            bucket_in = ev_bucket;
            head_ra   = ev_bucket;
         end
         ST_UNLINK: begin
            if (prev_v_ff) begin
               next_we = 1'b1;
               next_wa = prev_ff;
               next_wd = nxt_ff;
            end else begin
               head_we = 1'b1;
               head_wa = bucket_ff;
               head_wd = nxt_ff;
            end
            anext_ra = cur_ff;
         end
         ST_AGE: begin
            if (count_ff > CNT_W'(1)) begin
               if (cur_ff == oldest_ff) begin
                  oldest_in = anext_rd;
               end else begin
                  anext_we = 1'b1;
                  anext_wa = aprev_rd;
                  anext_wd = anext_rd;
               end
               if (cur_ff == newest_ff) begin
                  newest_in = aprev_rd;
               end else begin
                  aprev_we = 1'b1;
                  aprev_wa = anext_rd;
                  aprev_wd = aprev_rd;
               end
            end
            count_in = count_ff - 1'b1;
            if (evict_ff) begin
               slot_in = cur_ff;
            end else begin
               free_we = 1'b1;
               free_wa = SLOT_W'(top_ff);
               free_wd = cur_ff;
               top_in  = top_ff + 1'b1;
            end
         end
         ST_POP_WAIT: slot_in = free_rd;
         ST_INS_HEAD: head_ra = item_ff.bucket;
         ST_INS: begin
            key_we  = 1'b1;
            key_wa  = slot_ff;
            key_wd  = item_ff.ip;
            next_we = 1'b1;
            next_wa = slot_ff;
            next_wd = head_rd;
            head_we = 1'b1;
            head_wa = item_ff.bucket;
            head_wd = {1'b1, slot_ff};
            if (count_ff == '0) begin
               oldest_in = slot_ff;
            end else begin
               anext_we = 1'b1;
               anext_wa = newest_ff;
               anext_wd = slot_ff;
            end
            aprev_we  = 1'b1;
            aprev_wa  = slot_ff;
            aprev_wd  = newest_ff;
            newest_in = slot_ff;
            count_in  = count_ff + 1'b1;
         end
         ST_RESULT: begin
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff     <= ST_CLEAR;
         clr_ff    <= '0;
         oldest_ff <= '0;
         newest_ff <= '0;
         count_ff  <= '0;
         fill_ff   <= '0;
         top_ff    <= '0;
      end else begin
         st_ff     <= st_in;
         clr_ff    <= clr_in;
         oldest_ff <= oldest_in;
         newest_ff <= newest_in;
         count_ff  <= count_in;
         fill_ff   <= fill_in;
         top_ff    <= top_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff    <= item_in;
      bucket_ff  <= bucket_in;
      cur_ff     <= cur_in;
      prev_ff    <= prev_in;
      prev_v_ff  <= prev_v_in;
      nxt_ff     <= nxt_in;
      slot_ff    <= slot_in;
      evict_ff   <= evict_in;
      present_ff <= present_in;
      ev_ff      <= ev_in;
      ev_ip_ff   <= ev_ip_in;
   end

   // outputs
   always_comb begin
      clearing          = (st_ff == ST_CLEAR);
      rsp_strobe        = (st_ff == ST_RESULT);
      rsp_was_present   = present_ff;
      rsp_evicted_valid = ev_ff;
      rsp_evicted_ip    = ev_ip_ff;
      rsp_entry_total   = TOTAL_W'(count_ff);
   end

endmodule

FILE: hdl/ip_set_fifo_evict.sv
// top level of the bounded ip address set with oldest-first eviction
// usage:
//   command channel: req_op and req_ip are taken on a clock edge with start
//   high and busy low. op 0 queries, 1 adds, 2 deletes; op 3 acts as a query.
//   result channel: rsp_strobe is high for one cycle per item, in item order,
//   with rsp_was_present, rsp_evicted_valid, rsp_evicted_ip and the entry
//   count after the item on rsp_entry_total. the receiver cannot stall.
//   a two entry queue sits between the hashing front end and the back end,
//   so new commands are taken while an earlier one is still at work.
// steps per item: the back end reads the chain head of the item's bucket
// and walks the chain to a match or its end. a query, an add of a present
// address or a miss other than an add then gives its result; a delete that
// hits also unlinks the node and its age list entry; an add that misses
// reuses a freed slot or takes a fresh one, or when full first evicts the
// oldest address by walking its chain. the back end takes one item at a
// time, so a new item waits in the queue; the chain walk on the key and
//   link memories moves one node per cycle.
// reset:
//   synchronous reset empties the set; the chain head memory is then swept
//   clean one bucket per cycle, with busy held high.
module ip_set_fifo_evict (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic [isfe_pkg::OP_W-1:0]    req_op,
   input  logic [isfe_pkg::IP_W-1:0]    req_ip,
   output logic                         rsp_strobe,
   output logic                         rsp_was_present,
   output logic                         rsp_evicted_valid,
   output logic [isfe_pkg::IP_W-1:0]    rsp_evicted_ip,
   output logic [isfe_pkg::TOTAL_W-1:0] rsp_entry_total
);
   import isfe_pkg::*;

   qhead_type q_head;
   logic      q_full;
   logic      q_pop;
   logic      clearing;
   logic      transfer;

   // a command transfer happens when start meets a free queue slot outside the reset sweep
   assign busy     = q_full || clearing;
   assign transfer = start && !busy;

   isfe_front u_front (
      .clock (clock),
      .reset (reset),
      .push  (transfer),
      .op    (req_op),
      .ip    (req_ip),
      .pop   (q_pop),
      .full  (q_full),
      .head  (q_head)
   );

   isfe_back u_back (
      .clock             (clock),
      .reset             (reset),
      .head              (q_head),
      .pop               (q_pop),
      .clearing          (clearing),
      .rsp_strobe        (rsp_strobe),
      .rsp_was_present   (rsp_was_present),
      .rsp_evicted_valid (rsp_evicted_valid),
      .rsp_evicted_ip    (rsp_evicted_ip),
      .rsp_entry_total   (rsp_entry_total)
   );

endmodule

FILE: dv/isfe_checker.sv
// checker for the address set: follows both channels, predicts each result and compares
`timescale 1ns / 100ps

module isfe_checker (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic                         busy,
   input  logic [isfe_pkg::OP_W-1:0]    req_op,
   input  logic [isfe_pkg::IP_W-1:0]    req_ip,
   input  logic                         rsp_strobe,
   input  logic                         rsp_was_present,
   input  logic                         rsp_evicted_valid,
   input  logic [isfe_pkg::IP_W-1:0]    rsp_evicted_ip,
   input  logic [isfe_pkg::TOTAL_W-1:0] rsp_entry_total,
   output int                           pending,
   output int                           fail_count
);
   import isfe_pkg::*;

   typedef struct {
      logic               was_present;
      logic               ev_valid;
      logic [IP_W-1:0]    ev_ip;
      logic [TOTAL_W-1:0] total;
   } outcome_type;

   outcome_type     outcome_q[$];
   logic [IP_W-1:0] age_order[$];
   bit              member[logic [IP_W-1:0]];

   assign pending = outcome_q.size();

   task automatic report(input string field, input logic [IP_W-1:0] want,
                         input logic [IP_W-1:0] got);
      $display("%0t mismatch on %s: expected %h got %h", $realtime, field, want, got);
      fail_count++;
   endtask

   // set update for one command, result goes to the back of outcome_q
   function automatic void apply_cmd(input logic [OP_W-1:0] op, input logic [IP_W-1:0] ip);
      outcome_type o;
      o.was_present = member.exists(ip);
      o.ev_valid    = 1'b0;
      o.ev_ip       = '0;
      if (op == OP_ADD && !o.was_present) begin
         if (age_order.size() >= CAPACITY) begin
            o.ev_valid = 1'b1;
            o.ev_ip    = age_order.pop_front();
            member.delete(o.ev_ip);
         end
         age_order.push_back(ip);
         member[ip] = 1'b1;
      end else if (op == OP_DEL && o.was_present) begin
         member.delete(ip);
         foreach (age_order[i]) begin
            if (age_order[i] == ip) begin
               age_order.delete(i);
               break;
            end
         end
      end
      o.total = TOTAL_W'(age_order.size());
      outcome_q.push_back(o);
   endfunction

   always @(posedge clock) begin
      outcome_type o;
      if (reset) begin
         outcome_q.delete();
         age_order.delete();
         member.delete();
         fail_count = 0;
      end else begin
         if (rsp_strobe) begin
            if (outcome_q.size() == 0) begin
               $display("%0t result with nothing outstanding", $realtime);
               fail_count++;
            end else begin
               o = outcome_q.pop_front();
               if (rsp_was_present !== o.was_present)
                  report("was_present", IP_W'(o.was_present), IP_W'(rsp_was_present));
               if (rsp_evicted_valid !== o.ev_valid)
                  report("evicted_valid", IP_W'(o.ev_valid), IP_W'(rsp_evicted_valid));
               if (rsp_evicted_ip !== o.ev_ip)
                  report("evicted_ip", o.ev_ip, rsp_evicted_ip);
               if (rsp_entry_total !== o.total)
                  report("entry_total", IP_W'(o.total), IP_W'(rsp_entry_total));
            end
         end
         if (start && !busy)
            apply_cmd(req_op, req_ip);
      end
   end

endmodule

FILE: dv/tb_top.sv
// top of the address set testbench: clock, reset, command stimulus and verdict
`timescale 1ns / 100ps

module tb_top;
   import isfe_pkg::*;

   // op code 3 is unused and behaves as a query
   localparam logic [OP_W-1:0] OP_SPARE = 2'd3;

   logic                clock;
   logic                reset;
   logic                start;
   logic                busy;
   logic [OP_W-1:0]     req_op;
   logic [IP_W-1:0]     req_ip;
   logic                rsp_strobe;
   logic                rsp_was_present;
   logic                rsp_evicted_valid;
   logic [IP_W-1:0]     rsp_evicted_ip;
   logic [TOTAL_W-1:0]  rsp_entry_total;
   int                  pending;
   int                  fail_count;

   // recently added addresses, so queries, deletes and re-adds often hit
   logic [IP_W-1:0]     added_hist[$];

   ip_set_fifo_evict u_top (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_op            (req_op),
      .req_ip            (req_ip),
      .rsp_strobe        (rsp_strobe),
      .rsp_was_present   (rsp_was_present),
      .rsp_evicted_valid (rsp_evicted_valid),
      .rsp_evicted_ip    (rsp_evicted_ip),
      .rsp_entry_total   (rsp_entry_total)
   );

   isfe_checker u_checker (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_op            (req_op),
      .req_ip            (req_ip),
      .rsp_strobe        (rsp_strobe),
      .rsp_was_present   (rsp_was_present),
      .rsp_evicted_valid (rsp_evicted_valid),
      .rsp_evicted_ip    (rsp_evicted_ip),
      .rsp_entry_total   (rsp_entry_total),
      .pending           (pending),
      .fail_count        (fail_count)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // one command transfer: start stays high until the block takes it
   task automatic send(input logic [OP_W-1:0] op, input logic [IP_W-1:0] ip);
      start  <= 1'b1;
      req_op <= op;
      req_ip <= ip;
      do @(posedge clock); while (busy);
      if (op == OP_ADD) begin
         added_hist.push_back(ip);
         if (added_hist.size() > 256) void'(added_hist.pop_front());
      end
   endtask

   // random gap before the next command, about 8 in a hundred
   task automatic maybe_idle(input bit allow);
      if (allow && $urandom_range(99) < 8) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
   endtask

   // address: fresh with the given percentage, otherwise one seen recently
   function automatic logic [IP_W-1:0] pick_ip(input int fresh_pct);
      if (added_hist.size() == 0 || $urandom_range(99) < fresh_pct) return $urandom();
      return added_hist[$urandom_range(added_hist.size() - 1)];
   endfunction

   // fill_phase leans hard on fresh adds so the set reaches capacity;
   // later items mix all ops so evictions and deletes interleave
   task automatic random_cmd(input bit fill_phase);
      int r;
      r = $urandom_range(99);
      if (fill_phase) begin
         if (r < 88)      send(OP_ADD, pick_ip(92));
         else if (r < 94) send(OP_QUERY, pick_ip(30));
         else if (r < 98) send(OP_DEL, pick_ip(40));
         else             send(OP_SPARE, pick_ip(40));
      end else begin
         if (r < 50)      send(OP_ADD, pick_ip(60));
         else if (r < 72) send(OP_QUERY, pick_ip(40));
         else if (r < 94) send(OP_DEL, pick_ip(35));
         else             send(OP_SPARE, pick_ip(40));
      end
   endtask

   initial begin
      start  <= 1'b0;
      req_op <= OP_QUERY;
      req_ip <= '0;
      reset  <= 1'b1;
      repeat (8) @(posedge clock);
      reset  <= 1'b0;

      // directed: address extremes, every op, re-add, absent delete, spare op
      send(OP_QUERY, 32'h0000_0000);
      send(OP_ADD,   32'h0000_0000);
      send(OP_ADD,   32'h0000_0000);
      send(OP_QUERY, 32'h0000_0000);
      send(OP_ADD,   32'hFFFF_FFFF);
      send(OP_SPARE, 32'hFFFF_FFFF);
      send(OP_SPARE, 32'h1234_5678);
      send(OP_DEL,   32'h1234_5678);
      send(OP_DEL,   32'h0000_0000);
      send(OP_QUERY, 32'h0000_0000);
      send(OP_ADD,   32'h8000_0000);
      send(OP_ADD,   32'h0000_0001);
      send(OP_DEL,   32'hFFFF_FFFF);
      send(OP_ADD,   32'h5555_AAAA);
      send(OP_DEL,   32'h0000_0001);
      send(OP_QUERY, 32'h8000_0000);

      // fill toward capacity; items 400 to 799 run back to back
      for (int i = 0; i < 1300; i++) begin
         random_cmd(1'b1);
         maybe_idle(i < 400 || i >= 800);
      end

      // drain: hold off until the block has answered everything
      start <= 1'b0;
      while (pending != 0) @(posedge clock);

      // steady state at capacity, evictions mixed with deletes and re-adds
      for (int i = 0; i < 640; i++) begin
         random_cmd(1'b0);
         maybe_idle(1'b1);
      end
      start <= 1'b0;

      while (pending != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      if (fail_count == 0 && pending == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

   // watchdog, well past the slowest legal run including the reset sweep
   initial begin
      #8ms;
      $display("end of test: mismatches");
      $finish;
   end

endmodule
